// ===== sv/mvr_pkg.sv =====
// Package for the matrix-vector rotate core: field widths, fixed-point
// constants, the command that passes from front to back, and state codes.
// No dependencies.
package mvr_pkg;

  // Field widths of the streaming items
  localparam int OPCODE_W   = 2;
  localparam int IDX_W      = 6;
  localparam int DIM_W      = 7;
  localparam int DATA_W     = 16;
  localparam int OUT_W      = 24;
  localparam int IDX_RANGE  = 2 ** IDX_W;

  // Defaults handed to the top level
  localparam int MAX_DIM_DEF = 64;
  localparam int FIFO_DEPTH  = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Q2.14 x Q1.15 products, summed, shifted right and saturated
  localparam int SHIFT_BITS = 14;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = 40;
  localparam logic signed [ACC_W-1:0] OUT_MAX_ACC = 40'sd8388607;
  localparam logic signed [ACC_W-1:0] OUT_MIN_ACC = -40'sd8388608;

  // Input opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_MAT_WR  = 2'd0,
    OP_FORWARD = 2'd1,
    OP_INVERSE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  // Command kinds held in the queue
  typedef enum logic [0:0] {
    CMD_MAT = 1'b0,
    CMD_VEC = 1'b1
  } cmd_kind_t;

  // One classified command; for vector writes col carries the element index
  typedef struct packed {
    cmd_kind_t                kind;
    logic                     vec_wr;   // element index is inside the buffer
    logic                     run;      // start the product after this item
    logic                     inverse;  // use the transpose
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

endpackage

// ===== sv/mvr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/mvr_fifo.sv =====
// Short register queue between the front and back of the core.
// Depends on nothing but its parameters.
module mvr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/mvr_front.sv =====
// Front end: takes input items, drops those with no effect and turns the
// rest into queue commands. Depends on mvr_pkg.
module mvr_front #(
  parameter int MAX_DIM = mvr_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clearing,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mvr_pkg::OPCODE_W-1:0]      opcode,
  input  logic [mvr_pkg::IDX_W-1:0]         entry_row,
  input  logic [mvr_pkg::IDX_W-1:0]         entry_col,
  input  logic [mvr_pkg::IDX_W-1:0]         element_index,
  input  logic signed [mvr_pkg::DATA_W-1:0] value,
  input  logic                              last_element,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output mvr_pkg::cmd_t                     cmd
);

  localparam int SIDE = (MAX_DIM < mvr_pkg::IDX_RANGE) ? MAX_DIM : mvr_pkg::IDX_RANGE;
  localparam logic [mvr_pkg::DIM_W-1:0] SIDE_V = mvr_pkg::DIM_W'(SIDE);

  mvr_pkg::cmd_t cls;
  logic          keep;
  logic          accept;
  logic          row_ok;
  logic          col_ok;
  logic          idx_ok;

  assign row_ok = ({1'b0, entry_row} < SIDE_V);
  assign col_ok = ({1'b0, entry_col} < SIDE_V);
  assign idx_ok = ({1'b0, element_index} < SIDE_V);

  // Classify one item
  always_comb begin
    cls.kind    = mvr_pkg::CMD_MAT;
    cls.vec_wr  = 1'b0;
    cls.run     = 1'b0;
    cls.inverse = 1'b0;
    cls.row     = entry_row;
    cls.col     = entry_col;
    cls.value   = value;
    keep        = 1'b0;
    case (mvr_pkg::opcode_t'(opcode))
      mvr_pkg::OP_MAT_WR: begin
        keep = row_ok && col_ok;
      end
      mvr_pkg::OP_FORWARD, mvr_pkg::OP_INVERSE: begin
        cls.kind    = mvr_pkg::CMD_VEC;
        cls.col     = element_index;
        cls.vec_wr  = idx_ok;
        cls.run     = last_element;
        cls.inverse = (mvr_pkg::opcode_t'(opcode) == mvr_pkg::OP_INVERSE);
        keep        = idx_ok || last_element;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Holding stage in front of the queue
  assign in_ready = !clearing && (!cmd_valid || cmd_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cls;
    end
  end

endmodule

// ===== sv/mvr_back.sv =====
// Back end: owns the matrix store and vector buffer, runs the clearing
// pass, applies writes and runs the multiply-accumulate sequencer.
// Depends on mvr_pkg and mvr_ram.
module mvr_back #(
  parameter int MAX_DIM = mvr_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mvr_pkg::DIM_W-1:0]        dimension,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  mvr_pkg::cmd_t                    cmd,
  output logic                             clearing,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mvr_pkg::IDX_W-1:0]        out_index,
  output logic signed [mvr_pkg::OUT_W-1:0] out_value,
  output logic                             out_last
);

  localparam int SIDE   = (MAX_DIM < mvr_pkg::IDX_RANGE) ? MAX_DIM : mvr_pkg::IDX_RANGE;
  localparam int IW     = $clog2(SIDE);
  localparam int AW     = 2 * IW;
  localparam int VDEPTH = 2 ** IW;
  localparam int MDEPTH = 2 ** AW;
  localparam int DW     = mvr_pkg::DIM_W;
  localparam int DATA_W = mvr_pkg::DATA_W;
  localparam int ACC_W  = mvr_pkg::ACC_W;

  mvr_pkg::state_t state;
  logic [AW-1:0]   clr_addr;
  logic [IW-1:0]   k;
  logic [IW-1:0]   m;
  logic [DW-1:0]   dlast;
  logic            inverse;
  logic [VDEPTH-1:0] vvalid;

  logic                        s1_valid;
  logic                        s1_first;
  logic                        vv_q;
  logic                        s2_valid;
  logic                        s2_first;
  logic signed [mvr_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_shr;
  logic signed [mvr_pkg::OUT_W-1:0] sat;

  logic [DW-1:0]     dim_eff;
  logic              pop;
  logic              mat_we;
  logic [AW-1:0]     mat_waddr;
  logic [DATA_W-1:0] mat_wdata;
  logic [AW-1:0]     mat_raddr;
  logic [DATA_W-1:0] mat_rdata;
  logic              vec_we;
  logic [DATA_W-1:0] vec_rdata;
  logic [DATA_W-1:0] vec_opnd;
  logic              col_last;
  logic              row_last;
  logic              emit;

  assign clearing  = (state == mvr_pkg::ST_CLEAR);
  assign cmd_ready = (state == mvr_pkg::ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign col_last  = (DW'(m) == dlast);
  assign row_last  = (DW'(k) == dlast);
  assign emit      = (state == mvr_pkg::ST_DRAIN) && !s1_valid && !s2_valid &&
                     (!out_valid || out_ready);

  // Dimension in use: zero acts as one, large values clamp to the store side
  always_comb begin
    if (dimension == '0) begin
      dim_eff = DW'(1);
    end else if (dimension > DW'(SIDE)) begin
      dim_eff = DW'(SIDE);
    end else begin
      dim_eff = dimension;
    end
  end

  // Matrix store ports: clearing pass or entry write, row-major read (transposed for inverse)
  assign mat_we    = clearing || (pop && cmd.kind == mvr_pkg::CMD_MAT);
  assign mat_waddr = clearing ? clr_addr : {cmd.row[IW-1:0], cmd.col[IW-1:0]};
  assign mat_wdata = clearing ? '0 : cmd.value;
  assign mat_raddr = inverse ? {m, k} : {k, m};

  mvr_ram #(.WIDTH(DATA_W), .DEPTH(MDEPTH)) u_mat (
    .clk     (clk),
    .wr_en   (mat_we),
    .wr_addr (mat_waddr),
    .wr_data (mat_wdata),
    .rd_addr (mat_raddr),
    .rd_data (mat_rdata)
  );

  // Vector buffer; entries not written since the last product read as zero
  assign vec_we = pop && cmd.kind == mvr_pkg::CMD_VEC && cmd.vec_wr;

  mvr_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_vec (
    .clk     (clk),
    .wr_en   (vec_we),
    .wr_addr (cmd.col[IW-1:0]),
    .wr_data (cmd.value),
    .rd_addr (m),
    .rd_data (vec_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mvr_pkg::ST_CLEAR;
      clr_addr <= '0;
      vvalid   <= '0;
      k        <= '0;
      m        <= '0;
    end else begin
      case (state)
        mvr_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= mvr_pkg::ST_IDLE;
          end
        end
        mvr_pkg::ST_IDLE: begin
          if (vec_we) begin
            vvalid[cmd.col[IW-1:0]] <= 1'b1;
          end
          if (pop && cmd.kind == mvr_pkg::CMD_VEC && cmd.run) begin
            k     <= '0;
            m     <= '0;
            state <= mvr_pkg::ST_ISSUE;
          end
        end
        mvr_pkg::ST_ISSUE: begin
          if (col_last) begin
            m     <= '0;
            state <= mvr_pkg::ST_DRAIN;
          end else begin
            m <= m + 1'b1;
          end
        end
        mvr_pkg::ST_DRAIN: begin
          if (emit) begin
            if (row_last) begin
              vvalid <= '0;
              state  <= mvr_pkg::ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= mvr_pkg::ST_ISSUE;
            end
          end
        end
        default: begin
          state <= mvr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Run settings latched when the product starts
  always_ff @(posedge clk) begin
    if (pop && cmd.kind == mvr_pkg::CMD_VEC && cmd.run) begin
      dlast   <= dim_eff - 1'b1;
      inverse <= cmd.inverse;
    end
  end

  // Multiply-accumulate pipe: read, multiply, accumulate
  assign vec_opnd = vv_q ? vec_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == mvr_pkg::ST_ISSUE);
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (m == '0);
    vv_q     <= vvalid[m];
    s2_first <= s1_first;
    prod     <= $signed(mat_rdata) * $signed(vec_opnd);
    if (s2_valid) begin
      acc <= s2_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Scale by 2^-14 (floor) and saturate
  assign acc_shr = acc >>> mvr_pkg::SHIFT_BITS;

  always_comb begin
    if (acc_shr > mvr_pkg::OUT_MAX_ACC) begin
      sat = mvr_pkg::OUT_MAX_ACC[mvr_pkg::OUT_W-1:0];
    end else if (acc_shr < mvr_pkg::OUT_MIN_ACC) begin
      sat = mvr_pkg::OUT_MIN_ACC[mvr_pkg::OUT_W-1:0];
    end else begin
      sat = acc_shr[mvr_pkg::OUT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= mvr_pkg::IDX_W'(k);
      out_value <= sat;
      out_last  <= row_last;
    end
  end

  // Checks
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("multiply stage valid without a preceding read");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == mvr_pkg::ST_CLEAR) |-> !out_valid && !s1_valid && !s2_valid)
    else $error("activity during the clearing pass");

  a_buffer_cleared: assert property (@(posedge clk) disable iff (rst)
    (emit && row_last) |=> (vvalid == '0) && (state == mvr_pkg::ST_IDLE))
    else $error("vector buffer not cleared after the final result");

endmodule

// ===== sv/matrix_vector_rotate_core.sv =====
// Top level of the matrix-vector rotate core: stream ports, dimension
// register, front end, command queue and back end.
// Depends on mvr_pkg, mvr_front, mvr_fifo, mvr_back (and mvr_ram).
// Throughput: takes one item a cycle while the queue has room; the back end
//   pops nothing during a product, run on the single multiply-accumulate unit.
// Reset: clears the matrix store in a pass over every address with
//   s_axis_tready low; dimension resets to 64.
module matrix_vector_rotate_core #(
  parameter int MAX_DIM = mvr_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // entry_row[5:0] entry_col[11:6]
                                     // element_index[17:12] value[33:18]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  input  logic        s_axis_tlast,  // last_element
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_index[5:0] result_value[29:6]
  output logic        m_axis_tlast,  // last_result
  // dimension register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int CMD_W = $bits(mvr_pkg::cmd_t);

  logic [mvr_pkg::DIM_W-1:0] dimension;
  logic                      clearing;
  logic                      f_valid;
  logic                      f_ready;
  mvr_pkg::cmd_t             f_cmd;
  logic                      q_valid;
  logic                      q_ready;
  logic [CMD_W-1:0]          q_data;
  logic [mvr_pkg::IDX_W-1:0] res_index;
  logic signed [mvr_pkg::OUT_W-1:0] res_value;

  // Dimension register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= mvr_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dimension <= cfg_data;
    end
  end

  mvr_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk           (clk),
    .rst           (rst),
    .clearing      (clearing),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .opcode        (s_axis_tuser),
    .entry_row     (s_axis_tdata[5:0]),
    .entry_col     (s_axis_tdata[11:6]),
    .element_index (s_axis_tdata[17:12]),
    .value         ($signed(s_axis_tdata[33:18])),
    .last_element  (s_axis_tlast),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  mvr_fifo #(.WIDTH(CMD_W), .DEPTH(mvr_pkg::FIFO_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  mvr_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .dimension (dimension),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (mvr_pkg::cmd_t'(q_data)),
    .clearing  (clearing),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (res_index),
    .out_value (res_value),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, res_value, res_index};

endmodule

// ===== test/matrix_vector_rotate_core_tb.sv =====
// Testbench for matrix_vector_rotate_core: drives matrix entries, vector elements and
// dimension writes, predicts each product in a scoreboard class and checks every result.
// Depends on mvr_pkg and the RTL of matrix_vector_rotate_core.
`timescale 1ns / 100ps

module matrix_vector_rotate_core_tb;

  localparam int IDLE_PCT       = 13;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 480;
  localparam int MAX_REPORTS    = 10;
  localparam int SIDE           = mvr_pkg::MAX_DIM_DEF;

  // One output element of a product
  typedef struct packed {
    logic [mvr_pkg::IDX_W-1:0]        index;
    logic signed [mvr_pkg::OUT_W-1:0] value;
    logic                             last;
  } result_elem_t;

  // Scoreboard: holds its own matrix, vector and dimension and predicts products
  class product_scoreboard;
    logic signed [mvr_pkg::DATA_W-1:0] entries [SIDE*SIDE];
    logic signed [mvr_pkg::DATA_W-1:0] elements [SIDE];
    logic [mvr_pkg::DIM_W-1:0]         dimension;
    result_elem_t                      expected_elements [$];
    int                                mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      foreach (elements[i]) elements[i] = '0;
      dimension  = mvr_pkg::DIM_RESET;
      mismatches = 0;
    endfunction

    function void set_dimension(logic [mvr_pkg::DIM_W-1:0] d);
      dimension = d;
    endfunction

    // Accepted input item: update the store or run the product
    function void note_item(mvr_pkg::opcode_t op, logic [mvr_pkg::IDX_W-1:0] row,
                            logic [mvr_pkg::IDX_W-1:0] col, logic [mvr_pkg::IDX_W-1:0] idx,
                            logic signed [mvr_pkg::DATA_W-1:0] v, logic lst);
      int           d;
      longint       acc;
      longint       q;
      result_elem_t e;
      case (op)
        mvr_pkg::OP_MAT_WR: entries[{row, col}] = v;
        mvr_pkg::OP_FORWARD, mvr_pkg::OP_INVERSE: begin
          elements[idx] = v;
          if (lst) begin
            d = (dimension == '0) ? 1 : (int'(dimension) > SIDE) ? SIDE : int'(dimension);
            for (int k = 0; k < d; k++) begin
              acc = 0;
              for (int m = 0; m < d; m++) begin
                acc += longint'((op == mvr_pkg::OP_INVERSE) ? entries[m*SIDE+k]
                                                            : entries[k*SIDE+m])
                       * longint'(elements[m]);
              end
              // floor shift, then clamp to the output width
              q = acc >>> mvr_pkg::SHIFT_BITS;
              if (q > longint'(mvr_pkg::OUT_MAX_ACC)) q = longint'(mvr_pkg::OUT_MAX_ACC);
              if (q < longint'(mvr_pkg::OUT_MIN_ACC)) q = longint'(mvr_pkg::OUT_MIN_ACC);
              e.index = k[mvr_pkg::IDX_W-1:0];
              e.value = q[mvr_pkg::OUT_W-1:0];
              e.last  = (k == d - 1);
              expected_elements.push_back(e);
            end
            foreach (elements[i]) elements[i] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, result_elem_t want, result_elem_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s: expected index %0d value %0d last %0b, got index %0d value %0d last %0b",
                 $time, what, want.index, want.value, want.last,
                 got.index, got.value, got.last);
    endfunction

    // Accepted result item: compare with the oldest prediction
    function void check_result(result_elem_t got);
      result_elem_t want;
      if (expected_elements.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_elements.pop_front();
      if (got.index !== want.index || got.value !== want.value || got.last !== want.last)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // entry_row[5:0] entry_col[11:6] element_index[17:12] value[33:18]
  logic [1:0]  s_axis_tuser;   // opcode[1:0]
  logic        s_axis_tlast;   // last_element
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // result_index[5:0] result_value[29:6]
  logic        m_axis_tlast;   // last_result
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  product_scoreboard sb;
  bit                quiet;
  int                items_sent;
  int                stuck_cycles;

  matrix_vector_rotate_core u_top (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: random backpressure, except in the quiet stretch
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result checking and watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[5:0], m_axis_tdata[29:6], m_axis_tlast});
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int rand_value();
    case ($urandom_range(7))
      0:       return 'h7fff;
      1:       return 'h8000;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Send one input item, with random gaps before it
  task automatic send_item(mvr_pkg::opcode_t op, int row, int col, int idx, int v, int lst);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, v[15:0], idx[5:0], col[5:0], row[5:0]};
    s_axis_tlast  <= lst[0];
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, row[5:0], col[5:0], idx[5:0], v[15:0], lst[0]);
    if (op != mvr_pkg::OP_NONE) items_sent++;
  endtask

  // Hold the sender until all predicted results are in and the core has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dimension(logic [6:0] d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_dimension(d);
  endtask

  // Run: some entries, some elements, some out of range or flipped, then the last element
  task automatic run_vector(int d);
    int               n;
    mvr_pkg::opcode_t dir;
    mvr_pkg::opcode_t flip;
    dir  = $urandom_range(1) ? mvr_pkg::OP_INVERSE : mvr_pkg::OP_FORWARD;
    flip = (dir == mvr_pkg::OP_FORWARD) ? mvr_pkg::OP_INVERSE : mvr_pkg::OP_FORWARD;
    n = $urandom_range(0, (2 * d < 16) ? 2 * d : 16);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send_item(mvr_pkg::OP_MAT_WR, $urandom_range(63), $urandom_range(63),
                  $urandom_range(63), rand_value(), $urandom_range(1));
      else
        send_item(mvr_pkg::OP_MAT_WR, $urandom_range(d - 1), $urandom_range(d - 1),
                  $urandom_range(63), rand_value(), 0);
    end
    n = $urandom_range(0, (d < 16) ? d : 16);
    repeat (n) begin
      send_item(($urandom_range(6) == 0) ? flip : dir, $urandom_range(63), $urandom_range(63),
                ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(d - 1),
                rand_value(), 0);
    end
    send_item(dir, $urandom_range(63), $urandom_range(63),
              ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(d - 1),
              rand_value(), 1);
  endtask

  // Noise: dead opcodes, flagged entry writes, stray elements
  task automatic inject_noise();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(2))
        0: send_item(mvr_pkg::OP_NONE, $urandom_range(63), $urandom_range(63),
                     $urandom_range(63), rand_value(), $urandom_range(1));
        1: send_item(mvr_pkg::OP_MAT_WR, $urandom_range(63), $urandom_range(63),
                     $urandom_range(63), rand_value(), 1);
        default: send_item(mvr_pkg::opcode_t'($urandom_range(1, 2)), $urandom_range(63),
                           $urandom_range(63), $urandom_range(63), rand_value(), 0);
      endcase
    end
  endtask

  initial begin
    int dim_raw;
    int dim_eff;
    int phase_left;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    quiet         = 1'b0;
    items_sent    = 0;
    phase_left    = 0;
    sb            = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: corner entries at the reset dimension
    send_item(mvr_pkg::OP_MAT_WR, 0, 0, 0, 'h7fff, 0);
    send_item(mvr_pkg::OP_MAT_WR, 63, 63, 63, 'h8000, 0);
    send_item(mvr_pkg::OP_MAT_WR, 0, 63, 0, 'hffff, 0);
    send_item(mvr_pkg::OP_MAT_WR, 63, 0, 21, 'h4000, 0);
    // entry write carrying a last flag is just a write
    send_item(mvr_pkg::OP_MAT_WR, 42, 21, 42, 'h5a5a, 1);
    // dead opcode, even with the last flag
    send_item(mvr_pkg::OP_NONE, 21, 42, 63, 'hffff, 1);
    // forward product, one mixed-direction element on the way
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 0, 'h7fff, 0);
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 63, 'h8000, 0);
    send_item(mvr_pkg::OP_INVERSE, 0, 0, 21, 'h1234, 0);
    send_item(mvr_pkg::OP_FORWARD, 63, 63, 42, 'hffff, 1);
    // inverse product decided by the last element alone
    send_item(mvr_pkg::OP_INVERSE, 0, 0, 0, 'h8000, 0);
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 63, 'h7fff, 0);
    send_item(mvr_pkg::OP_INVERSE, 0, 0, 1, 1, 1);
    // buffer must be cleared after a product
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 5, 0, 1);
    // dimension zero acts as one; element above it is stored but unused
    wait_idle();
    write_dimension(7'd0);
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 3, 100, 0);
    send_item(mvr_pkg::OP_INVERSE, 0, 0, 0, 'h7fff, 1);
    // oversize dimension clamps to the full matrix
    wait_idle();
    write_dimension(7'd127);
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 63, 'h8000, 1);
    wait_idle();
    write_dimension(7'd1);
    send_item(mvr_pkg::OP_FORWARD, 0, 0, 0, 'h8000, 1);

    // Random: phases of a few runs, each phase at a fresh dimension
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        wait_idle();
        case ($urandom_range(99)) inside
          [0:69]:  dim_raw = $urandom_range(1, 8);
          [70:84]: dim_raw = $urandom_range(9, 16);
          [85:89]: dim_raw = 0;
          [90:93]: dim_raw = $urandom_range(65, 127);
          [94:96]: dim_raw = 64;
          default: dim_raw = $urandom_range(17, 40);
        endcase
        write_dimension(7'(dim_raw));
        dim_eff    = (dim_raw == 0) ? 1 : (dim_raw > 64) ? 64 : dim_raw;
        phase_left = $urandom_range(2, 6);
      end
      quiet = (items_sent >= 220 && items_sent < 300);
      if ($urandom_range(99) < 85)
        run_vector(dim_eff);
      else
        inject_noise();
      phase_left--;
    end
    quiet = 1'b0;

    wait_idle();
    if (sb.mismatches == 0 && sb.expected_elements.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
